### rtl/sorted_key_value_table_top_defines.svh
// ----------------------------------------------------------------------------
// Sorted key/value table: assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_VALUE_TABLE_TOP_DEFINES_SVH
`define SORTED_KEY_VALUE_TABLE_TOP_DEFINES_SVH

// same-cycle implication
`define SKVT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted table check failed");

// next-cycle implication
`define SKVT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted table check failed");

`endif

### rtl/skvt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key/value table: shared package
// Sizes, command and register codes, cell/tree types, key compare helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package skvt_pkg;

    localparam int DEPTH      = 64;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 7;
    localparam int CMD_BITS   = 4;

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int LEVELS = $clog2(DEPTH);
    localparam int LEAVES = 1 << LEVELS;

    localparam int IN_DATA_W  = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((VALUE_BITS + KEY_BITS + COUNT_BITS + 7) / 8) * 8;
    localparam int OUT_USER_W = 2;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;

    // commands
    localparam logic [CMD_BITS-1:0] CMD_SET    = 4'd0;
    localparam logic [CMD_BITS-1:0] CMD_GET    = 4'd1;
    localparam logic [CMD_BITS-1:0] CMD_EXISTS = 4'd2;
    localparam logic [CMD_BITS-1:0] CMD_DELETE = 4'd3;
    localparam logic [CMD_BITS-1:0] CMD_FIRST  = 4'd4;
    localparam logic [CMD_BITS-1:0] CMD_LAST   = 4'd5;
    localparam logic [CMD_BITS-1:0] CMD_NEXT   = 4'd6;
    localparam logic [CMD_BITS-1:0] CMD_PREV   = 4'd7;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 4'd8;

    // config register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SIGNED_KEYS = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MISS_VALUE  = 1'b1;

    // cell update operations
    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_INSERT = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    typedef logic [KEY_BITS-1:0]   key_t;
    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [IDX_W-1:0]      idx_t;

    localparam key_t KEY_SIGN = key_t'(1) << (KEY_BITS - 1);

    // per-cell compare result, also the node type of the reduction tree
    typedef struct packed {
        logic   match;
        idx_t   match_idx;
        value_t match_val;
        cnt_t   lt_cnt;
        logic   gt_ok;
        key_t   gt_key;
        logic   lt_ok;
        key_t   lt_key;
        key_t   last_key;
    } node_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic       cmp_en;
        logic [1:0] op;
        cnt_t       at;
        key_t       key;
        value_t     value;
        logic       sgn;
        cnt_t       count;
    } ctrl_t;

    function automatic logic key_less(key_t a, key_t b, logic sgn);
        key_t flip;
        flip = sgn ? KEY_SIGN : '0;
        return (a ^ flip) < (b ^ flip);
    endfunction

    function automatic node_t node_combine(node_t a, node_t b, logic sgn);
        node_t r;
        r.match     = a.match | b.match;
        r.match_idx = a.match_idx | b.match_idx;
        r.match_val = a.match_val | b.match_val;
        r.lt_cnt    = a.lt_cnt + b.lt_cnt;
        if (a.gt_ok && (!b.gt_ok || key_less(a.gt_key, b.gt_key, sgn)))
        begin
            r.gt_ok  = 1'b1;
            r.gt_key = a.gt_key;
        end
        else
        begin
            r.gt_ok  = b.gt_ok;
            r.gt_key = b.gt_key;
        end
        if (a.lt_ok && (!b.lt_ok || key_less(b.lt_key, a.lt_key, sgn)))
        begin
            r.lt_ok  = 1'b1;
            r.lt_key = a.lt_key;
        end
        else
        begin
            r.lt_ok  = b.lt_ok;
            r.lt_key = b.lt_key;
        end
        r.last_key = a.last_key | b.last_key;
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/skvt_cell.sv
// ----------------------------------------------------------------------------
// Sorted key/value table: storage cell
// One slot: compares against the broadcast key, shifts with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module skvt_cell (
    input  logic                     clk,
    input  logic [skvt_pkg::IDX_W-1:0] idx,
    input  skvt_pkg::ctrl_t          ctrl,
    input  skvt_pkg::key_t           left_key,
    input  skvt_pkg::value_t         left_val,
    input  skvt_pkg::key_t           right_key,
    input  skvt_pkg::value_t         right_val,
    output skvt_pkg::key_t           key_q,
    output skvt_pkg::value_t         val_q,
    output skvt_pkg::node_t          leaf
);
    import skvt_pkg::*;

    key_t   key_reg,  key_next;
    value_t val_reg,  val_next;
    node_t  leaf_reg, leaf_next;
    cnt_t   pos;
    logic   valid, hit, below, above, is_last;

    always_comb
    begin
        pos     = CNT_W'(idx);
        valid   = pos < ctrl.count;
        hit     = valid && (key_reg == ctrl.key);
        below   = valid && key_less(key_reg, ctrl.key, ctrl.sgn);
        above   = valid && key_less(ctrl.key, key_reg, ctrl.sgn);
        is_last = valid && ((pos + CNT_W'(1)) == ctrl.count);

        leaf_next = leaf_reg;
        if (ctrl.cmp_en)
        begin
            leaf_next.match     = hit;
            leaf_next.match_idx = hit ? idx : '0;
            leaf_next.match_val = hit ? val_reg : '0;
            leaf_next.lt_cnt    = CNT_W'(below);
            leaf_next.gt_ok     = above;
            leaf_next.gt_key    = key_reg;
            leaf_next.lt_ok     = below;
            leaf_next.lt_key    = key_reg;
            leaf_next.last_key  = is_last ? key_reg : '0;
        end

        key_next = key_reg;
        val_next = val_reg;
        unique case (ctrl.op)
            OP_UPDATE:
            begin
                if (pos == ctrl.at)
                begin
                    val_next = ctrl.value;
                end
            end
            OP_INSERT:
            begin
                if (pos == ctrl.at)
                begin
                    key_next = ctrl.key;
                    val_next = ctrl.value;
                end
                else if (pos > ctrl.at)
                begin
                    key_next = left_key;
                    val_next = left_val;
                end
            end
            OP_REMOVE:
            begin
                if (pos >= ctrl.at)
                begin
                    key_next = right_key;
                    val_next = right_val;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        val_reg  <= val_next;
        leaf_reg <= leaf_next;
    end

    assign key_q = key_reg;
    assign val_q = val_reg;
    assign leaf  = leaf_reg;

endmodule

`default_nettype wire

### rtl/skvt_tree.sv
// ----------------------------------------------------------------------------
// Sorted key/value table: reduction tree
// Registered binary tree over the cell results, one level per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module skvt_tree (
    input  logic            clk,
    input  logic            signed_keys,
    input  skvt_pkg::node_t leaves [skvt_pkg::DEPTH],
    output skvt_pkg::node_t root
);
    import skvt_pkg::*;

    node_t leaf_w   [LEAVES];
    node_t node_reg [1:LEAVES-1];

    genvar gl, gn;

    // pad to a power of two with empty nodes
    for (gl = 0; gl < LEAVES; gl++)
    begin : g_leaf
        if (gl < DEPTH)
        begin : g_real
            assign leaf_w[gl] = leaves[gl];
        end
        else
        begin : g_pad
            assign leaf_w[gl] = '0;
        end
    end

    // heap order: node k has children 2k and 2k+1
    for (gn = 1; gn < LEAVES; gn++)
    begin : g_node
        node_t lo, hi;
        if (2 * gn >= LEAVES)
        begin : g_bottom
            assign lo = leaf_w[2 * gn - LEAVES];
            assign hi = leaf_w[2 * gn + 1 - LEAVES];
        end
        else
        begin : g_inner
            assign lo = node_reg[2 * gn];
            assign hi = node_reg[2 * gn + 1];
        end

        always_ff @(posedge clk)
        begin
            node_reg[gn] <= node_combine(lo, hi, signed_keys);
        end
    end

    assign root = node_reg[1];

endmodule

`default_nettype wire

### rtl/sorted_key_value_table_top.sv
// Operation: a taken request is compared in the cells, then walks the
//   log2(DEPTH)-level registered compare tree, and its result is registered
//   from ST_DONE; one request is in flight at a time, and a new request may
//   enter while the previous result still waits on the output register.
// Reset: async active-low; clears control, count and config registers. Slot
//   contents are not cleared, the entry count marks which slots are live.
// ----------------------------------------------------------------------------
// Sorted key/value table: top level
// Chain of storage cells kept in key order, with a shared reduction tree.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_value_table_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration writes
    input  logic                              cfg_we,
    input  logic [skvt_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [skvt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [skvt_pkg::IN_DATA_W-1:0]    s_tdata,   // key[31:0], value[63:32]
    input  logic [skvt_pkg::CMD_BITS-1:0]     s_tuser,   // cmd
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [skvt_pkg::OUT_DATA_W-1:0]   m_tdata,   // value_out, key_out, entry_count, pad
    output logic [skvt_pkg::OUT_USER_W-1:0]   m_tuser    // ok, table_full
);
    import skvt_pkg::*;

    localparam int LVL_W = $clog2(LEVELS + 1);

    // sequencer: take request, compare in cells, walk the tree, retire
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_TREE = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]        state_reg,   state_next;
    logic [LVL_W-1:0]  lvl_cnt_reg, lvl_cnt_next;
    cnt_t              count_reg,   count_next;
    logic              signed_keys_reg;
    value_t            miss_value_reg;
    logic              out_valid_reg, out_valid_next;

    // request payload held for the whole operation
    logic [CMD_BITS-1:0] cmd_reg;
    key_t                key_reg;
    value_t              value_reg;

    // result payload
    logic   out_ok_reg,  ok_next;
    logic   out_full_reg, full_next;
    value_t out_value_reg, vout_next;
    key_t   out_key_reg,   kout_next;
    cnt_t   out_count_reg;

    logic       in_fire, done_fire;
    logic [1:0] op_next;
    cnt_t       at_next;
    ctrl_t      ctrl;
    node_t      root;

    key_t   key_q  [DEPTH];
    value_t val_q  [DEPTH];
    node_t  leaf_q [DEPTH];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign done_fire = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // ---- cell chain ----
    assign ctrl.cmp_en = (state_reg == ST_CMP);
    assign ctrl.op     = done_fire ? op_next : OP_HOLD;
    assign ctrl.at     = at_next;
    assign ctrl.key    = key_reg;
    assign ctrl.value  = value_reg;
    assign ctrl.sgn    = signed_keys_reg;
    assign ctrl.count  = count_reg;

    genvar gi;
    for (gi = 0; gi < DEPTH; gi++)
    begin : g_cell
        key_t   lk, rk;
        value_t lv, rv;
        if (gi == 0)
        begin : g_head
            assign lk = '0;
            assign lv = '0;
        end
        else
        begin : g_left
            assign lk = key_q[gi - 1];
            assign lv = val_q[gi - 1];
        end
        if (gi == DEPTH - 1)
        begin : g_tail
            assign rk = '0;
            assign rv = '0;
        end
        else
        begin : g_right
            assign rk = key_q[gi + 1];
            assign rv = val_q[gi + 1];
        end

        skvt_cell u_cell (
            .clk       (clk),
            .idx       (IDX_W'(gi)),
            .ctrl      (ctrl),
            .left_key  (lk),
            .left_val  (lv),
            .right_key (rk),
            .right_val (rv),
            .key_q     (key_q[gi]),
            .val_q     (val_q[gi]),
            .leaf      (leaf_q[gi])
        );
    end

    skvt_tree u_tree (
        .clk         (clk),
        .signed_keys (signed_keys_reg),
        .leaves      (leaf_q),
        .root        (root)
    );

    // ---- result and cell update decode, valid in ST_DONE ----
    always_comb
    begin
        ok_next    = 1'b0;
        full_next  = 1'b0;
        vout_next  = miss_value_reg;
        kout_next  = '0;
        count_next = count_reg;
        op_next    = OP_HOLD;
        at_next    = '0;
        unique case (cmd_reg)
            CMD_SET:
            begin
                if (root.match)
                begin
                    op_next = OP_UPDATE;
                    at_next = CNT_W'(root.match_idx);
                    ok_next = 1'b1;
                end
                else if (count_reg == CNT_W'(DEPTH))
                begin
                    full_next = 1'b1;
                end
                else
                begin
                    // new key lands after every key that compares below it
                    op_next    = OP_INSERT;
                    at_next    = root.lt_cnt;
                    count_next = count_reg + CNT_W'(1);
                    ok_next    = 1'b1;
                end
            end
            CMD_GET:
            begin
                if (root.match)
                begin
                    ok_next   = 1'b1;
                    vout_next = root.match_val;
                end
            end
            CMD_EXISTS:
            begin
                ok_next = root.match;
            end
            CMD_DELETE:
            begin
                if (root.match)
                begin
                    op_next    = OP_REMOVE;
                    at_next    = CNT_W'(root.match_idx);
                    count_next = count_reg - CNT_W'(1);
                    ok_next    = 1'b1;
                end
            end
            CMD_FIRST:
            begin
                if (count_reg != '0)
                begin
                    ok_next   = 1'b1;
                    kout_next = key_q[0];
                end
            end
            CMD_LAST:
            begin
                if (count_reg != '0)
                begin
                    ok_next   = 1'b1;
                    kout_next = root.last_key;
                end
            end
            CMD_NEXT:
            begin
                ok_next   = root.gt_ok;
                kout_next = root.gt_ok ? root.gt_key : '0;
            end
            CMD_PREV:
            begin
                ok_next   = root.lt_ok;
                kout_next = root.lt_ok ? root.lt_key : '0;
            end
            CMD_CLEAR:
            begin
                count_next = '0;
                ok_next    = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // ---- sequencer ----
    always_comb
    begin
        state_next   = state_reg;
        lvl_cnt_next = lvl_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next   = ST_TREE;
                lvl_cnt_next = '0;
            end
            ST_TREE:
            begin
                // one tree level registers per cycle
                if (lvl_cnt_reg == LVL_W'(LEVELS - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    lvl_cnt_next = lvl_cnt_reg + LVL_W'(1);
                end
            end
            ST_DONE:
            begin
                if (done_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (done_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lvl_cnt_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_cnt_reg   <= lvl_cnt_next;
            out_valid_reg <= out_valid_next;
            if (done_fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    // ---- configuration registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_keys_reg <= 1'b0;
            miss_value_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SIGNED_KEYS: signed_keys_reg <= cfg_wdata[0];
                REG_MISS_VALUE:  miss_value_reg  <= VALUE_BITS'(cfg_wdata);
                default:
                begin
                end
            endcase
        end
    end

    // ---- payload registers ----
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg   <= s_tuser;
            key_reg   <= s_tdata[KEY_BITS-1:0];
            value_reg <= s_tdata[KEY_BITS +: VALUE_BITS];
        end
        if (done_fire)
        begin
            out_ok_reg    <= ok_next;
            out_full_reg  <= full_next;
            out_value_reg <= vout_next;
            out_key_reg   <= kout_next;
            out_count_reg <= count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({COUNT_BITS'(out_count_reg), out_key_reg, out_value_reg});
    assign m_tuser  = {out_full_reg, out_ok_reg};

endmodule

`default_nettype wire

### rtl/skvt_checker.sv
// ----------------------------------------------------------------------------
// Sorted key/value table: port checker
// Watches the top-level streams for sequencing and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_key_value_table_top_defines.svh"

module skvt_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [skvt_pkg::OUT_DATA_W-1:0]  m_tdata,
    input wire logic [skvt_pkg::OUT_USER_W-1:0]  m_tuser
);
    import skvt_pkg::*;

    localparam int COUNT_LSB = VALUE_BITS + KEY_BITS;

    logic [COUNT_BITS-1:0] out_count;

    assign out_count = m_tdata[COUNT_LSB +: COUNT_BITS];

    // stalled result must not move
    `SKVT_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tuser, m_tdata}))
    // one request in flight: ready drops right after a request is taken
    `SKVT_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
    // a refused insert never reports success
    `SKVT_ASSERT_IMPL(a_full_not_ok, m_tvalid, !(m_tuser[0] && m_tuser[1]))
    // refusal only when every slot is taken
    `SKVT_ASSERT_IMPL(a_full_at_depth, m_tvalid && m_tuser[1], out_count == COUNT_BITS'(DEPTH))
    // entry count never exceeds capacity
    `SKVT_ASSERT_IMPL(a_count_bound, m_tvalid, out_count <= COUNT_BITS'(DEPTH))

endmodule

bind sorted_key_value_table_top skvt_checker u_skvt_checker (.*);

`default_nettype wire
